FILE: sv/vvfm_pkg.sv
// Shared types, codes and helper functions for the voxel visible face mask block.
package vvfm_pkg;

  // Field widths of the stream items.
  localparam int unsigned COORD_W = 4;
  localparam int unsigned DIR_W   = 3;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned TOTAL_W = 15;
  localparam int unsigned NUM_DIRS = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Item kinds carried on tuser.
  localparam logic [1:0] OP_WR_BLOCK  = 2'd0;
  localparam logic [1:0] OP_WR_BORDER = 2'd1;
  localparam logic [1:0] OP_CLASSIFY  = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  // Axis of a direction code, taken from its upper two bits.
  localparam logic [1:0] AXIS_Z = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_X = 2'd2;

  // Where the bit for a neighbour comes from.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_CUBE,
    SRC_BORDER
  } src_e;

  // Range flags produced by the neighbour address unit.
  typedef struct packed {
    logic centre_ok;
    logic plane_ok;
    logic nbr_in;
  } vvfm_flags_t;

  function automatic logic [COUNT_W-1:0] mask_ones(input logic [MASK_W-1:0] mask);
    logic [COUNT_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      cnt = cnt + COUNT_W'(mask[i]);
    end
    return cnt;
  endfunction

endpackage

FILE: sv/voxel_visible_face_mask.sv
// Top level of the voxel visible face mask block: sequencer, stores and result register.
//
// Input items arrive on the s_axis channel. tuser carries the item kind: write a block
// transparency bit, write a border plane bit, classify a block, or clear the face total.
// tdata carries the block coordinates, the border direction and the transparency bit.
// Every item yields exactly one result transfer on m_axis: the visible face mask, its
// face count and the running face total after the item.
// The cfg channel writes the six neighbour-present bits; it is always ready and must
// only be used while the block is idle.
// A classify item runs through a small sequencer that makes seven reads of the
// registered-read stores, one per cycle: the block itself, then the six neighbours in
// mask bit order. Writes and clears skip the reads and go straight to the result
// stage. No new item is taken until the current result has moved into the output
// register. The block store has a single read port, which the centre read and the
// in-chunk neighbour reads share.
// s_axis_tready is high only while the sequencer is idle; a finished result sits in an
// output register, so a stalled receiver holds back at most the next item's result.
// Reset clears the sequencer, the output valid, the face total and the neighbour bits;
// the transparency stores are not cleared and must be written before they are read.
module voxel_visible_face_mask import vvfm_pkg::*; #(
  parameter int unsigned CHUNK_EDGE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // x_coord[3:0], y_coord[7:4], z_coord[11:8], face_dir[14:12], transparent_bit[15]
  input  logic [15:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // face_mask[5:0], face_count[8:6], total_faces[23:9]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int unsigned Aw     = $clog2(CHUNK_EDGE);
  localparam int unsigned CubeAw = 3 * Aw;
  localparam int unsigned BordAw = DIR_W + 2 * Aw;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] STEP_CENTRE = 3'd0;
  localparam logic [2:0] STEP_FIRST  = 3'd1;
  localparam logic [2:0] STEP_LAST   = 3'd7;

  // Input fields.
  logic [COORD_W-1:0] in_x, in_y, in_z;
  logic [DIR_W-1:0]   in_dir;
  logic               in_t;
  logic [1:0]         in_op;
  logic               in_acc;

  assign in_x   = s_axis_tdata[3:0];
  assign in_y   = s_axis_tdata[7:4];
  assign in_z   = s_axis_tdata[11:8];
  assign in_dir = s_axis_tdata[14:12];
  assign in_t   = s_axis_tdata[15];
  assign in_op  = s_axis_tuser;

  // Sequencer state.
  logic [1:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  src_e               src_q, src_d;
  logic               centre_clear_q, centre_clear_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [MASK_W-1:0]  res_mask_q, res_mask_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;
  logic [NUM_DIRS-1:0] present_q, present_d;
  logic               m_valid_q, m_valid_d;
  logic [23:0]        m_data_q, m_data_d;

  // Neighbour address unit, fed from the input while idle and from the latched block
  // coordinates while running.
  logic [COORD_W-1:0] u_x, u_y, u_z;
  logic [DIR_W-1:0]   u_dir;
  vvfm_flags_t        flags;
  logic [CubeAw-1:0]  centre_addr, nbr_addr;
  logic [BordAw-1:0]  border_addr;

  always_comb begin
    if (state_q == ST_IDLE) begin
      u_x   = in_x;
      u_y   = in_y;
      u_z   = in_z;
      u_dir = in_dir;
    end else begin
      u_x   = x_q;
      u_y   = y_q;
      u_z   = z_q;
      u_dir = step_q - 3'd1;
    end
  end

  vvfm_nbr #(
    .CHUNK_EDGE(CHUNK_EDGE)
  ) u_nbr (
    .x_i          (u_x),
    .y_i          (u_y),
    .z_i          (u_z),
    .dir_i        (u_dir),
    .flags_o      (flags),
    .centre_addr_o(centre_addr),
    .nbr_addr_o   (nbr_addr),
    .border_addr_o(border_addr)
  );

  // Transparency stores.
  logic              cube_we, border_we;
  logic [CubeAw-1:0] cube_raddr;
  logic              cube_rdata, border_rdata;

  assign in_acc     = s_axis_tvalid & s_axis_tready;
  assign cube_we    = in_acc & (in_op == OP_WR_BLOCK) & flags.centre_ok;
  assign border_we  = in_acc & (in_op == OP_WR_BORDER) & flags.plane_ok;
  assign cube_raddr = (step_q == STEP_CENTRE) ? centre_addr : nbr_addr;

  vvfm_ram #(
    .WIDTH(1),
    .DEPTH(1 << CubeAw)
  ) u_cube_ram (
    .clk_i  (clk_i),
    .we_i   (cube_we),
    .waddr_i(centre_addr),
    .wdata_i(in_t),
    .raddr_i(cube_raddr),
    .rdata_o(cube_rdata)
  );

  vvfm_ram #(
    .WIDTH(1),
    .DEPTH(1 << BordAw)
  ) u_border_ram (
    .clk_i  (clk_i),
    .we_i   (border_we),
    .waddr_i(border_addr),
    .wdata_i(in_t),
    .raddr_i(border_addr),
    .rdata_o(border_rdata)
  );

  // The bit read in the previous cycle, according to where it was fetched from.
  logic              bit_prev;
  logic [2:0]        bit_idx;
  logic [MASK_W-1:0] mask_upd;
  logic [MASK_W-1:0] final_mask;
  logic [COUNT_W-1:0] final_count;
  logic [TOTAL_W:0]  total_sum;

  always_comb begin
    case (src_q)
      SRC_CUBE:   bit_prev = cube_rdata;
      SRC_BORDER: bit_prev = border_rdata;
      default:    bit_prev = 1'b0;
    endcase
    bit_idx     = step_q - 3'd2;
    mask_upd    = mask_q | (MASK_W'(bit_prev) << bit_idx);
    final_mask  = centre_clear_q ? '0 : mask_upd;
    final_count = mask_ones(final_mask);
    total_sum   = {1'b0, total_q} + (TOTAL_W + 1)'(final_count);
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    src_d          = src_q;
    centre_clear_d = centre_clear_q;
    mask_d         = mask_q;
    x_d            = x_q;
    y_d            = y_q;
    z_d            = z_q;
    total_d        = total_q;
    res_mask_d     = res_mask_q;
    res_count_d    = res_count_q;
    present_d      = present_q;
    m_valid_d      = m_valid_q;
    m_data_d       = m_data_q;

    if (cfg_valid_i) begin
      present_d = cfg_data_i;
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_mask_d  = '0;
          res_count_d = '0;
          state_d     = ST_FIN;
          case (in_op)
            OP_CLASSIFY: begin
              if (flags.centre_ok) begin
                x_d     = in_x;
                y_d     = in_y;
                z_d     = in_z;
                step_d  = STEP_CENTRE;
                mask_d  = '0;
                state_d = ST_RUN;
              end
            end
            OP_CLEAR: begin
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RUN: begin
        // Pick the source of the read issued in this step.
        if (step_q == STEP_CENTRE) begin
          src_d = SRC_CUBE;
        end else if (flags.nbr_in) begin
          src_d = SRC_CUBE;
        end else if (present_q[u_dir]) begin
          src_d = SRC_BORDER;
        end else begin
          src_d = SRC_NONE;
        end

        // Take in the bit read in the previous step.
        if (step_q == STEP_FIRST) begin
          centre_clear_d = cube_rdata;
        end else if (step_q != STEP_CENTRE) begin
          mask_d = mask_upd;
        end

        if (step_q == STEP_LAST) begin
          res_mask_d  = final_mask;
          res_count_d = final_count;
          total_d     = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          state_d     = ST_FIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end

      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {total_q, res_count_q, res_mask_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= STEP_CENTRE;
      src_q     <= SRC_NONE;
      total_q   <= '0;
      present_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      src_q     <= src_d;
      total_q   <= total_d;
      present_q <= present_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    centre_clear_q <= centre_clear_d;
    mask_q         <= mask_d;
    x_q            <= x_d;
    y_q            <= y_d;
    z_q            <= z_d;
    res_mask_q     <= res_mask_d;
    res_count_q    <= res_count_d;
    m_data_q       <= m_data_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The sequencer only starts a walk right after an input transfer.
  a_run_starts_on_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_CENTRE) |-> $past(in_acc))
    else $error("classify walk started without an input transfer");

  // The face count shown always matches the mask beside it.
  a_count_matches_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[8:6] == mask_ones(m_data_q[5:0])))
    else $error("face count does not match face mask");

  // The running total only falls through a clear item.
  a_total_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && in_op == OP_CLEAR) |=> (total_q >= $past(total_q)))
    else $error("face total decreased without a clear");

endmodule

FILE: sv/vvfm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module vvfm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/vvfm_nbr.sv
// Shared neighbour address unit: one increment or decrement on the selected axis.
module vvfm_nbr import vvfm_pkg::*; #(
  parameter int unsigned CHUNK_EDGE = 16
) (
  input  logic [COORD_W-1:0]                    x_i,
  input  logic [COORD_W-1:0]                    y_i,
  input  logic [COORD_W-1:0]                    z_i,
  input  logic [DIR_W-1:0]                      dir_i,
  output vvfm_flags_t                           flags_o,
  output logic [3*$clog2(CHUNK_EDGE)-1:0]       centre_addr_o,
  output logic [3*$clog2(CHUNK_EDGE)-1:0]       nbr_addr_o,
  output logic [DIR_W+2*$clog2(CHUNK_EDGE)-1:0] border_addr_o
);

  localparam int unsigned Aw    = $clog2(CHUNK_EDGE);
  localparam logic [6:0]  EdgeW = 7'(CHUNK_EDGE);

  logic [1:0]         axis;
  logic               neg;
  logic [COORD_W-1:0] a_coord;
  logic [COORD_W:0]   n_coord;
  logic               n_ok;
  logic [COORD_W:0]   nx, ny, nz;
  logic [COORD_W-1:0] p_coord, q_coord;
  logic               x_ok, y_ok, z_ok, p_ok, q_ok;

  assign x_ok = 7'(x_i) < EdgeW;
  assign y_ok = 7'(y_i) < EdgeW;
  assign z_ok = 7'(z_i) < EdgeW;

  always_comb begin
    axis = dir_i[2:1];
    neg  = dir_i[0];
    case (axis)
      AXIS_Z:  a_coord = z_i;
      AXIS_Y:  a_coord = y_i;
      default: a_coord = x_i;
    endcase

    // The one adder of the unit: step the chosen axis by one.
    if (neg) begin
      n_coord = {1'b0, a_coord} - 5'd1;
      n_ok    = a_coord != '0;
    end else begin
      n_coord = {1'b0, a_coord} + 5'd1;
      n_ok    = 7'(n_coord) < EdgeW;
    end

    nx = {1'b0, x_i};
    ny = {1'b0, y_i};
    nz = {1'b0, z_i};
    case (axis)
      AXIS_Z:  nz = n_coord;
      AXIS_Y:  ny = n_coord;
      default: nx = n_coord;
    endcase

    // In-plane coordinates of the border plane facing this direction.
    case (axis)
      AXIS_Z: begin
        p_coord = x_i;
        q_coord = y_i;
        p_ok    = x_ok;
        q_ok    = y_ok;
      end
      AXIS_Y: begin
        p_coord = x_i;
        q_coord = z_i;
        p_ok    = x_ok;
        q_ok    = z_ok;
      end
      default: begin
        p_coord = y_i;
        q_coord = z_i;
        p_ok    = y_ok;
        q_ok    = z_ok;
      end
    endcase
  end

  assign flags_o.centre_ok = x_ok & y_ok & z_ok;
  assign flags_o.plane_ok  = (dir_i < DIR_W'(NUM_DIRS)) & p_ok & q_ok;
  assign flags_o.nbr_in    = n_ok;

  assign centre_addr_o = {Aw'(x_i), Aw'(y_i), Aw'(z_i)};
  assign nbr_addr_o    = {Aw'(nx), Aw'(ny), Aw'(nz)};
  assign border_addr_o = {dir_i, Aw'(p_coord), Aw'(q_coord)};

endmodule

FILE: sim/voxel_visible_face_mask_tb.sv
// Self-checking testbench for the voxel visible face mask block.
module voxel_visible_face_mask_tb;
  import vvfm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE           = 16;
  localparam int CUBE_CELLS     = EDGE * EDGE * EDGE;
  localparam int PLANE_CELLS    = EDGE * EDGE;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int SETTLE_CYCLES  = 12;
  localparam int OPEN_AIR_RUNS  = 30;

  // Direction codes in mask bit order; the last two are not valid planes.
  typedef enum logic [2:0] {
    DIR_POS_Z, DIR_NEG_Z, DIR_POS_Y, DIR_NEG_Y, DIR_POS_X, DIR_NEG_X, DIR_RSVD6, DIR_RSVD7
  } face_dir_e;

  // Input item as carried on s_axis_tdata, lowest field last.
  typedef struct packed {
    logic                transparent;
    logic [DIR_W-1:0]    dir;
    logic [COORD_W-1:0]  z;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  x;
  } voxel_item_t;

  // Result as carried on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic [MASK_W-1:0]  mask;
  } face_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic [15:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i    = '0;

  // Shadow copy of the block's stores, with a written flag per entry so that
  // the stimulus never classifies against a bit that was never loaded.
  bit block_transparent [CUBE_CELLS];
  bit block_written     [CUBE_CELLS];
  bit border_transparent [NUM_DIRS][PLANE_CELLS];
  bit border_written     [NUM_DIRS][PLANE_CELLS];
  logic [TOTAL_W-1:0] running_total      = '0;
  logic [NUM_DIRS-1:0] neighbours_present = '0;

  face_result_t pending_faces[$];
  int items_sent     = 0;
  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  voxel_visible_face_mask #(
    .CHUNK_EDGE(EDGE)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Border planes are addressed by the two coordinates across the plane; the
  // coordinate along the axis is ignored.
  function automatic logic [7:0] plane_index(input logic [2:0] dir, input logic [3:0] x,
                                             input logic [3:0] y, input logic [3:0] z);
    case (dir[2:1])
      AXIS_Z:  return {x, y};
      AXIS_Y:  return {x, z};
      default: return {y, z};
    endcase
  endfunction

  // Works out the adjacent block in a direction and says whether it lies in the chunk.
  function automatic bit neighbour_cell(input logic [2:0] dir, input logic [3:0] x,
                                        input logic [3:0] y, input logic [3:0] z,
                                        output logic [11:0] pos);
    int nx, ny, nz;
    nx = x;
    ny = y;
    nz = z;
    case (face_dir_e'(dir))
      DIR_POS_Z: nz = nz + 1;
      DIR_NEG_Z: nz = nz - 1;
      DIR_POS_Y: ny = ny + 1;
      DIR_NEG_Y: ny = ny - 1;
      DIR_POS_X: nx = nx + 1;
      DIR_NEG_X: nx = nx - 1;
      default: ;
    endcase
    pos = {nx[3:0], ny[3:0], nz[3:0]};
    return nx >= 0 && nx < EDGE && ny >= 0 && ny < EDGE && nz >= 0 && nz < EDGE;
  endfunction

  // A face shows when whatever lies beyond it is transparent; beyond the chunk
  // edge an absent neighbour hides it.
  function automatic bit face_open(input logic [2:0] dir, input logic [3:0] x,
                                   input logic [3:0] y, input logic [3:0] z);
    logic [11:0] pos;
    if (neighbour_cell(dir, x, y, z, pos)) return block_transparent[pos];
    if (!neighbours_present[dir]) return 1'b0;
    return border_transparent[dir][plane_index(dir, x, y, z)];
  endfunction

  // True when every bit that a classify of this block would look at has been loaded.
  function automatic bit classify_defined(input logic [3:0] x, input logic [3:0] y,
                                          input logic [3:0] z);
    logic [11:0] pos;
    if (!block_written[{x, y, z}]) return 1'b0;
    if (block_transparent[{x, y, z}]) return 1'b1;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (neighbour_cell(3'(d), x, y, z, pos)) begin
        if (!block_written[pos]) return 1'b0;
      end else if (neighbours_present[d] && !border_written[d][plane_index(3'(d), x, y, z)]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Applies one accepted item to the shadow state and returns the result it must give.
  function automatic face_result_t predict_faces(input logic [1:0] op, input voxel_item_t it);
    face_result_t res;
    logic [11:0] pos;
    logic [TOTAL_W:0] sum;
    res = '0;
    pos = {it.x, it.y, it.z};
    case (op)
      OP_WR_BLOCK: begin
        block_transparent[pos] = it.transparent;
        block_written[pos]     = 1'b1;
      end
      OP_WR_BORDER: begin
        // Direction codes past the last plane write nothing.
        if (it.dir < NUM_DIRS) begin
          border_transparent[it.dir][plane_index(it.dir, it.x, it.y, it.z)] = it.transparent;
          border_written[it.dir][plane_index(it.dir, it.x, it.y, it.z)]     = 1'b1;
        end
      end
      OP_CLASSIFY: begin
        // A transparent block shows no faces and leaves the total alone.
        if (!block_transparent[pos]) begin
          for (int d = 0; d < NUM_DIRS; d++) begin
            if (face_open(3'(d), it.x, it.y, it.z)) begin
              res.mask[d] = 1'b1;
              res.count   = res.count + 1'b1;
            end
          end
          // The total sticks at its maximum rather than wrapping.
          sum = running_total + res.count;
          running_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
      end
      OP_CLEAR: running_total = '0;
      default: ;
    endcase
    res.total = running_total;
    return res;
  endfunction

  // Offers one item on the input stream, with random idle cycles beforehand, and
  // records its expected result at the edge where the transfer takes place.
  task automatic send_item(input logic [1:0] op, input logic [3:0] x, input logic [3:0] y,
                           input logic [3:0] z, input logic [2:0] dir, input logic t);
    voxel_item_t it;
    it = '{transparent: t, dir: dir, z: z, y: y, x: x};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_faces.push_back(predict_faces(op, it));
    items_sent++;
  endtask

  // The register may only change while the block is idle, so every outstanding
  // result is collected first.
  task automatic write_neighbours(input logic [5:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    neighbours_present = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinates lean towards the chunk faces, where the border planes come in.
  function automatic logic [3:0] pick_coord();
    case ($urandom_range(3))
      0:       return 4'd0;
      1:       return 4'(EDGE - 1);
      default: return 4'($urandom_range(EDGE - 1));
    endcase
  endfunction

  // Loads a block and what surrounds it, with random content, then classifies it.
  task automatic run_visibility_sequence();
    logic [3:0] cx, cy, cz, bx, by, bz;
    logic [11:0] pos;
    logic [7:0] plane;
    bit refresh;
    cx = pick_coord();
    cy = pick_coord();
    cz = pick_coord();
    if (!block_written[{cx, cy, cz}] || $urandom_range(3) == 0) begin
      send_item(OP_WR_BLOCK, cx, cy, cz, 3'($urandom_range(7)), $urandom_range(99) < 20);
    end
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (neighbour_cell(3'(d), cx, cy, cz, pos)) begin
        if (!block_written[pos] || $urandom_range(1) == 0) begin
          send_item(OP_WR_BLOCK, pos[11:8], pos[7:4], pos[3:0], 3'($urandom_range(7)),
                    1'($urandom_range(1)));
        end
      end else begin
        plane = plane_index(3'(d), cx, cy, cz);
        // Planes of absent neighbours are sometimes left unloaded: they are never read.
        if (!border_written[d][plane]) refresh = neighbours_present[d] || $urandom_range(1);
        else refresh = ($urandom_range(3) == 0);
        if (refresh) begin
          bx = cx;
          by = cy;
          bz = cz;
          case (d[2:1])
            AXIS_Z:  bz = 4'($urandom_range(EDGE - 1));
            AXIS_Y:  by = 4'($urandom_range(EDGE - 1));
            default: bx = 4'($urandom_range(EDGE - 1));
          endcase
          send_item(OP_WR_BORDER, bx, by, bz, 3'(d), 1'($urandom_range(1)));
        end
      end
    end
    if (classify_defined(cx, cy, cz)) begin
      send_item(OP_CLASSIFY, cx, cy, cz, 3'($urandom_range(7)), 1'($urandom_range(1)));
      if ($urandom_range(4) == 0) begin
        send_item(OP_CLASSIFY, cx, cy, cz, 3'($urandom_range(7)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Any item with fully random fields; clears are kept rare so the total can grow.
  task automatic send_noise_item();
    voxel_item_t it;
    logic [1:0] op;
    it = voxel_item_t'(16'($urandom));
    op = 2'($urandom_range(3));
    if (op == OP_CLEAR && $urandom_range(3) != 0) op = OP_WR_BORDER;
    if (op == OP_CLASSIFY && !classify_defined(it.x, it.y, it.z)) op = OP_WR_BLOCK;
    send_item(op, it.x, it.y, it.z, it.dir, it.transparent);
  endtask

  // Both chunk corners, border planes with ignored axis coordinates, invalid
  // plane codes, a transparent block, and the neighbour bits at both extremes.
  task automatic test_edge_cases();
    send_item(OP_CLEAR, 0, 0, 0, DIR_POS_Z, 1'b0);
    send_item(OP_WR_BLOCK, 0, 0, 0, DIR_NEG_X, 1'b0);
    send_item(OP_WR_BLOCK, 1, 0, 0, DIR_POS_Z, 1'b1);
    send_item(OP_WR_BLOCK, 0, 1, 0, DIR_POS_Z, 1'b1);
    send_item(OP_WR_BLOCK, 0, 0, 1, DIR_POS_Z, 1'b1);
    send_item(OP_WR_BORDER, 0, 0, 15, DIR_NEG_Z, 1'b1);
    send_item(OP_WR_BORDER, 0, 15, 0, DIR_NEG_Y, 1'b1);
    send_item(OP_WR_BORDER, 15, 0, 0, DIR_NEG_X, 1'b1);
    send_item(OP_CLASSIFY, 0, 0, 0, DIR_RSVD7, 1'b1);
    send_item(OP_WR_BLOCK, 15, 15, 15, DIR_POS_Z, 1'b0);
    send_item(OP_WR_BLOCK, 14, 15, 15, DIR_POS_Z, 1'b0);
    send_item(OP_WR_BLOCK, 15, 14, 15, DIR_POS_Z, 1'b0);
    send_item(OP_WR_BLOCK, 15, 15, 14, DIR_POS_Z, 1'b1);
    send_item(OP_WR_BORDER, 15, 15, 0, DIR_POS_Z, 1'b1);
    send_item(OP_WR_BORDER, 15, 0, 15, DIR_POS_Y, 1'b1);
    send_item(OP_WR_BORDER, 0, 15, 15, DIR_POS_X, 1'b0);
    send_item(OP_CLASSIFY, 15, 15, 15, DIR_NEG_X, 1'b0);
    send_item(OP_WR_BORDER, 15, 15, 15, DIR_RSVD6, 1'b1);
    send_item(OP_WR_BORDER, 15, 15, 15, DIR_RSVD7, 1'b0);
    send_item(OP_CLASSIFY, 1, 0, 0, DIR_POS_Z, 1'b0);
    write_neighbours(6'h3F);
    send_item(OP_CLASSIFY, 0, 0, 0, DIR_POS_Z, 1'b0);
    send_item(OP_CLASSIFY, 15, 15, 15, DIR_POS_Z, 1'b0);
    send_item(OP_CLEAR, 15, 15, 15, DIR_RSVD7, 1'b1);
    send_item(OP_CLASSIFY, 15, 15, 15, DIR_POS_Z, 1'b1);
  endtask

  // Mostly well-formed load-then-classify sequences, with noise mixed in.
  task automatic test_random_traffic(input logic [5:0] present, input int idle_pct,
                                     input int stall_pct, input int n_items);
    int first;
    write_neighbours(present);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(99) < 25) send_noise_item();
      else run_visibility_sequence();
    end
  endtask

  // An opaque block in open air scores six faces per classify, back to back,
  // so the total climbs by the full count each time; a clear then brings it back.
  task automatic test_open_air_block();
    logic [11:0] pos;
    write_neighbours(6'h3F);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_WR_BLOCK, 7, 7, 7, DIR_POS_Z, 1'b0);
    for (int d = 0; d < NUM_DIRS; d++) begin
      void'(neighbour_cell(3'(d), 7, 7, 7, pos));
      send_item(OP_WR_BLOCK, pos[11:8], pos[7:4], pos[3:0], DIR_POS_Z, 1'b1);
    end
    for (int n = 0; n < OPEN_AIR_RUNS; n++) begin
      send_item(OP_CLASSIFY, 7, 7, 7, DIR_POS_Z, 1'b0);
    end
    send_item(OP_CLEAR, 7, 7, 7, DIR_POS_Z, 1'b0);
    send_item(OP_CLASSIFY, 7, 7, 7, DIR_POS_Z, 1'b0);
  endtask

  // Result checker: each transfer on the output stream is matched against the
  // oldest expectation. The ready is redrawn every cycle for the stall pattern.
  always @(posedge clk_i) begin
    face_result_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = face_result_t'(m_axis_tdata);
      if (pending_faces.size() == 0) begin
        $error("result transfer with no item outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_faces.pop_front();
        if (seen.mask !== want.mask) begin
          $error("face_mask: expected %h, got %h", want.mask, seen.mask);
          fail_count++;
        end
        if (seen.count !== want.count) begin
          $error("face_count: expected %0d, got %0d", want.count, seen.count);
          fail_count++;
        end
        if (seen.total !== want.total) begin
          $error("total_faces: expected %0d, got %0d", want.total, seen.total);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Counts cycles in which no transfer happens on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_random_traffic(6'h3F, 0, 0, 470);
    test_random_traffic(6'h00, 49, 0, 470);
    test_random_traffic(6'($urandom_range(63)), 0, 49, 470);
    test_random_traffic(6'b010101 ^ 6'($urandom_range(1) * 63), 16, 16, 470);
    test_open_air_block();

    s_axis_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
